/* rtl/gda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg: shared types, codes and calendar helpers for the date engine
// Holds the sequencer states, operation and order codes, width constants
// and the month length and leap count functions.
// ----------------------------------------------------------------------------
package gda_pkg;

    // default parameter values
    localparam int MAX_YEAR_DEF       = 9999;
    localparam int DAY_COUNT_BITS_DEF = 20;

    // field widths
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;
    localparam int YEAR_BITS  = 14;
    localparam int DIFF_BITS  = 22;
    localparam int ORDER_BITS = 2;
    localparam int OP_BITS    = 2;

    // year width for leap arithmetic, covers years up to 65536
    localparam int YEAR_CALC_BITS = 17;
    // running day total, signed
    localparam int ACC_BITS = 25;

    // calendar constants
    localparam int DAYS_PER_YEAR    = 365;
    localparam int MONTHS_PER_YEAR  = 12;
    localparam int FEB_DAYS         = 28;
    localparam int LONG_MONTH_DAYS  = 31;
    localparam int SHORT_MONTH_DAYS = 30;
    localparam int CENTURY          = 100;
    localparam int DIFF_MAX         = 4194303;

    // reciprocal of 100 scaled by 2^23, exact for years up to 65536
    localparam int RECIP_100       = 83887;
    localparam int RECIP_100_SHIFT = 23;

    typedef logic signed [ACC_BITS-1:0] acc_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_DIFF = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [ORDER_BITS-1:0] {
        ORDER_EQUAL   = 2'd0,
        ORDER_EARLIER = 2'd1,
        ORDER_LATER   = 2'd2
    } order_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF_START,
        ST_YEAR_MUL,
        ST_YEAR_HI,
        ST_YEAR_LO,
        ST_MONTH_WALK,
        ST_FIRST_MONTH,
        ST_LAST_DAY,
        ST_SHIFT_ADD,
        ST_SHIFT_SUB,
        ST_RANGE_CHECK,
        ST_OUT
    } state_t;

    // floor(y / 100) by reciprocal multiply
    function automatic logic [YEAR_CALC_BITS-1:0] div100(
        input logic [YEAR_CALC_BITS-1:0] y
    );
        logic [2*YEAR_CALC_BITS-1:0] prod;
        prod = (2*YEAR_CALC_BITS)'(y) * (2*YEAR_CALC_BITS)'(RECIP_100);
        return YEAR_CALC_BITS'(prod >> RECIP_100_SHIFT);
    endfunction

    // 4/100/400 rule
    function automatic logic is_leap(input logic [YEAR_CALC_BITS-1:0] y);
        logic [YEAR_CALC_BITS-1:0] q;
        logic [YEAR_CALC_BITS-1:0] rem;
        q   = div100(y);
        rem = y - YEAR_CALC_BITS'(q * YEAR_CALC_BITS'(CENTURY));
        return ((y[1:0] == 2'd0) && (rem != '0)) || ((rem == '0) && (q[1:0] == 2'd0));
    endfunction

    // leap years among 1..y
    function automatic logic [YEAR_CALC_BITS-1:0] leaps_upto(
        input logic [YEAR_CALC_BITS-1:0] y
    );
        logic [YEAR_CALC_BITS-1:0] q;
        q = div100(y);
        return (y >> 2) - q + (q >> 2);
    endfunction

    // days in month; unknown month numbers count 30
    function automatic logic [DAY_BITS-1:0] month_len(
        input logic [MONTH_BITS-1:0]     m,
        input logic [YEAR_CALC_BITS-1:0] y
    );
        logic [DAY_BITS-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_BITS'(LONG_MONTH_DAYS);
            4'd2:    len = DAY_BITS'(FEB_DAYS) + DAY_BITS'(is_leap(y));
            default: len = DAY_BITS'(SHORT_MONTH_DAYS);
        endcase
        return len;
    endfunction

endpackage

/* rtl/gregorian_date_arithmetic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic: date difference and day offset engine
// Difference: equal dates go straight to the result; otherwise the engine
//   sums one month per cycle, with each year and day term on the shared adder.
// Add or subtract: the date is walked one month per cycle
//   (about day_count / 30 months), then range checked.
// Throughput: one word at a time; s_ready is high only while idle.
// Reset: synchronous active-low aresetn returns the sequencer to idle.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic #(
    parameter int MAX_YEAR       = gda_pkg::MAX_YEAR_DEF,
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gda_pkg::OP_BITS-1:0]     s_operation,
    input  logic [gda_pkg::DAY_BITS-1:0]    s_first_day,
    input  logic [gda_pkg::MONTH_BITS-1:0]  s_first_month,
    input  logic [gda_pkg::YEAR_BITS-1:0]   s_first_year,
    input  logic [gda_pkg::DAY_BITS-1:0]    s_second_day,
    input  logic [gda_pkg::MONTH_BITS-1:0]  s_second_month,
    input  logic [gda_pkg::YEAR_BITS-1:0]   s_second_year,
    input  logic [DAY_COUNT_BITS-1:0]       s_day_count,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gda_pkg::DIFF_BITS-1:0]   m_day_difference,
    output logic [gda_pkg::ORDER_BITS-1:0]  m_date_order,
    output logic [gda_pkg::DAY_BITS-1:0]    m_result_day,
    output logic [gda_pkg::MONTH_BITS-1:0]  m_result_month,
    output logic [gda_pkg::YEAR_BITS-1:0]   m_result_year,
    output logic                            m_range_error
);

    localparam int DB  = gda_pkg::DAY_BITS;
    localparam int MB  = gda_pkg::MONTH_BITS;
    localparam int YB  = gda_pkg::YEAR_BITS;
    localparam int YC  = gda_pkg::YEAR_CALC_BITS;
    localparam int YMAX_IN = (1 << YB) - 1;
    // walking year must hold one past the larger of input range and MAX_YEAR
    localparam int WY  = $clog2(((MAX_YEAR > YMAX_IN) ? MAX_YEAR : YMAX_IN) + 2);
    // day count may grow by a few days on the first step past an odd day
    localparam int DW  = DAY_COUNT_BITS + 1;
    localparam int SW  = DW + 1;
    localparam int KB  = YB + MB + DB;

    // sequencer and datapath registers
    gda_pkg::state_t   state_reg, state_next;
    gda_pkg::op_t      op_reg, op_next;
    gda_pkg::order_t   order_reg, order_next;
    logic [DB-1:0]     fd_reg, fd_next, sd_reg, sd_next;
    logic [MB-1:0]     fm_reg, fm_next, sm_reg, sm_next;
    logic [YB-1:0]     fy_reg, fy_next, sy_reg, sy_next;
    gda_pkg::acc_t     acc_reg, acc_next;
    logic [4:0]        walk_i_reg, walk_i_next;
    logic [4:0]        walk_end_reg, walk_end_next;
    logic [YB-1:0]     walk_year_reg, walk_year_next;
    logic              walk_second_reg, walk_second_next;
    logic [DB-1:0]     cur_d_reg, cur_d_next;
    logic [MB-1:0]     cur_m_reg, cur_m_next;
    logic [WY-1:0]     cur_y_reg, cur_y_next;
    logic [DW-1:0]     days_reg, days_next;
    logic              bad_reg, bad_next;

    // earlier (l) and later (r) date of a difference
    logic              swap;
    logic [DB-1:0]     ld, rd;
    logic [MB-1:0]     lm, rm;
    logic [YB-1:0]     ly, ry;
    logic [YB-1:0]     ydiff;
    logic              span_ok;
    logic [22:0]       year_days;
    logic              same_month;

    // shared adder
    gda_pkg::acc_t     term;
    logic              term_en;

    // input compare
    logic [KB-1:0]     key_first, key_second;

    // shift step helpers
    logic [DB-1:0]     len_cur, len_walk, len_l, len_prev;
    logic [SW-1:0]     add_sum;
    logic [WY-1:0]     y_inc;
    logic [MB-1:0]     m_prev;
    logic [WY-1:0]     y_prev;

    logic [gda_pkg::DIFF_BITS-1:0] diff_clamped;
    logic              diff_sel, shift_sel;

    // order and swap
    assign key_first  = {s_first_year, s_first_month, s_first_day};
    assign key_second = {s_second_year, s_second_month, s_second_day};
    assign swap = (order_reg == gda_pkg::ORDER_LATER);
    assign ld   = swap ? sd_reg : fd_reg;
    assign lm   = swap ? sm_reg : fm_reg;
    assign ly   = swap ? sy_reg : fy_reg;
    assign rd   = swap ? fd_reg : sd_reg;
    assign rm   = swap ? fm_reg : sm_reg;
    assign ry   = swap ? fy_reg : sy_reg;

    // whole years strictly between the two dates
    assign ydiff      = ry - ly;
    assign span_ok    = (ydiff >= YB'(2));
    assign year_days  = 23'(ydiff - YB'(1)) * 23'(gda_pkg::DAYS_PER_YEAR);
    assign same_month = (ly == ry) && (lm == rm);

    // month lengths
    assign len_cur  = gda_pkg::month_len(cur_m_reg, YC'(cur_y_reg));
    assign len_walk = gda_pkg::month_len(walk_i_reg[MB-1:0], YC'(walk_year_reg));
    assign len_l    = gda_pkg::month_len(lm, YC'(ly));

    // add walk step
    assign add_sum = SW'(days_reg) + SW'(cur_d_reg);
    assign y_inc   = cur_y_reg + WY'(1);

    // subtract walk step: previous month, wrapping into the prior year
    always_comb begin
        if (cur_m_reg <= MB'(1)) begin
            m_prev = MB'(gda_pkg::MONTHS_PER_YEAR);
            y_prev = cur_y_reg - WY'(1);
        end else begin
            m_prev = cur_m_reg - MB'(1);
            y_prev = cur_y_reg;
        end
    end
    assign len_prev = gda_pkg::month_len(m_prev, YC'(y_prev));

    // select the term for the shared adder
    always_comb begin
        term    = '0;
        term_en = 1'b0;
        case (state_reg)
            gda_pkg::ST_YEAR_MUL: begin
                term_en = span_ok;
                term    = gda_pkg::acc_t'(year_days);
            end
            gda_pkg::ST_YEAR_HI: begin
                term_en = span_ok;
                term    = gda_pkg::acc_t'(gda_pkg::leaps_upto(YC'(ry - YB'(1))));
            end
            gda_pkg::ST_YEAR_LO: begin
                term_en = span_ok;
                term    = -gda_pkg::acc_t'(gda_pkg::leaps_upto(YC'(ly)));
            end
            gda_pkg::ST_MONTH_WALK: begin
                term_en = (walk_i_reg < walk_end_reg);
                term    = gda_pkg::acc_t'(len_walk);
            end
            gda_pkg::ST_FIRST_MONTH: begin
                term_en = 1'b1;
                term    = same_month ? -gda_pkg::acc_t'(ld)
                                     : gda_pkg::acc_t'(len_l) - gda_pkg::acc_t'(ld);
            end
            gda_pkg::ST_LAST_DAY: begin
                term_en = 1'b1;
                term    = gda_pkg::acc_t'(rd);
            end
            default: begin
                term_en = 1'b0;
                term    = '0;
            end
        endcase
    end

    // next state and datapath
    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        order_next       = order_reg;
        fd_next          = fd_reg;
        fm_next          = fm_reg;
        fy_next          = fy_reg;
        sd_next          = sd_reg;
        sm_next          = sm_reg;
        sy_next          = sy_reg;
        acc_next         = term_en ? (acc_reg + term) : acc_reg;
        walk_i_next      = walk_i_reg;
        walk_end_next    = walk_end_reg;
        walk_year_next   = walk_year_reg;
        walk_second_next = walk_second_reg;
        cur_d_next       = cur_d_reg;
        cur_m_next       = cur_m_reg;
        cur_y_next       = cur_y_reg;
        days_next        = days_reg;
        bad_next         = bad_reg;

        case (state_reg)
            gda_pkg::ST_IDLE: begin
                // take a word and load the working date
                if (s_valid) begin
                    op_next    = gda_pkg::op_t'(s_operation);
                    fd_next    = s_first_day;
                    fm_next    = s_first_month;
                    fy_next    = s_first_year;
                    sd_next    = s_second_day;
                    sm_next    = s_second_month;
                    sy_next    = s_second_year;
                    acc_next   = '0;
                    cur_d_next = s_first_day;
                    cur_m_next = s_first_month;
                    cur_y_next = WY'(s_first_year);
                    days_next  = DW'(s_day_count);
                    bad_next   = 1'b0;
                    if (key_first == key_second) begin
                        order_next = gda_pkg::ORDER_EQUAL;
                    end else if (key_first < key_second) begin
                        order_next = gda_pkg::ORDER_EARLIER;
                    end else begin
                        order_next = gda_pkg::ORDER_LATER;
                    end
                    case (gda_pkg::op_t'(s_operation))
                        gda_pkg::OP_DIFF: state_next = gda_pkg::ST_DIFF_START;
                        gda_pkg::OP_ADD:  state_next = gda_pkg::ST_SHIFT_ADD;
                        gda_pkg::OP_SUB:  state_next = gda_pkg::ST_SHIFT_SUB;
                        default:          state_next = gda_pkg::ST_OUT;
                    endcase
                end
            end

            gda_pkg::ST_DIFF_START: begin
                // finish at once for equal dates, else pick year span or same-year month walk
                if (order_reg == gda_pkg::ORDER_EQUAL) begin
                    state_next = gda_pkg::ST_OUT;
                end else if (ly != ry) begin
                    state_next = gda_pkg::ST_YEAR_MUL;
                end else begin
                    walk_i_next      = 5'(lm) + 5'd1;
                    walk_end_next    = 5'(rm);
                    walk_year_next   = ly;
                    walk_second_next = 1'b0;
                    state_next       = gda_pkg::ST_MONTH_WALK;
                end
            end

            gda_pkg::ST_YEAR_MUL: state_next = gda_pkg::ST_YEAR_HI;
            gda_pkg::ST_YEAR_HI:  state_next = gda_pkg::ST_YEAR_LO;

            gda_pkg::ST_YEAR_LO: begin
                // rest of the earlier year
                walk_i_next      = 5'(lm) + 5'd1;
                walk_end_next    = 5'(gda_pkg::MONTHS_PER_YEAR + 1);
                walk_year_next   = ly;
                walk_second_next = 1'b0;
                state_next       = gda_pkg::ST_MONTH_WALK;
            end

            gda_pkg::ST_MONTH_WALK: begin
                // one month per cycle
                if (walk_i_reg < walk_end_reg) begin
                    walk_i_next = walk_i_reg + 5'd1;
                end else if (walk_second_reg) begin
                    state_next = gda_pkg::ST_LAST_DAY;
                end else begin
                    state_next = gda_pkg::ST_FIRST_MONTH;
                end
            end

            gda_pkg::ST_FIRST_MONTH: begin
                // leading months of the later year
                if (ly != ry) begin
                    walk_i_next      = 5'd1;
                    walk_end_next    = 5'(rm);
                    walk_year_next   = ry;
                    walk_second_next = 1'b1;
                    state_next       = gda_pkg::ST_MONTH_WALK;
                end else begin
                    state_next = gda_pkg::ST_LAST_DAY;
                end
            end

            gda_pkg::ST_LAST_DAY: state_next = gda_pkg::ST_OUT;

            gda_pkg::ST_SHIFT_ADD: begin
                // advance one month, finish inside the current one, or flag a range error past MAX_YEAR
                if (days_reg == '0) begin
                    state_next = gda_pkg::ST_RANGE_CHECK;
                end else if (add_sum <= SW'(len_cur)) begin
                    cur_d_next = DB'(add_sum);
                    days_next  = '0;
                    state_next = gda_pkg::ST_RANGE_CHECK;
                end else begin
                    days_next  = DW'(add_sum - SW'(len_cur) - SW'(1));
                    cur_d_next = DB'(1);
                    if (cur_m_reg >= MB'(gda_pkg::MONTHS_PER_YEAR)) begin
                        cur_m_next = MB'(1);
                        cur_y_next = y_inc;
                        if (y_inc > WY'(MAX_YEAR)) begin
                            bad_next   = 1'b1;
                            state_next = gda_pkg::ST_OUT;
                        end
                    end else begin
                        cur_m_next = cur_m_reg + MB'(1);
                    end
                end
            end

            gda_pkg::ST_SHIFT_SUB: begin
                // step back one month, finish inside the current one, or flag a range error before year 1
                if (days_reg == '0) begin
                    state_next = gda_pkg::ST_RANGE_CHECK;
                end else if (days_reg < DW'(cur_d_reg)) begin
                    cur_d_next = cur_d_reg - DB'(days_reg);
                    days_next  = '0;
                    state_next = gda_pkg::ST_RANGE_CHECK;
                end else if ((cur_m_reg <= MB'(1)) && (cur_y_reg <= WY'(1))) begin
                    bad_next   = 1'b1;
                    state_next = gda_pkg::ST_OUT;
                end else begin
                    days_next  = days_reg - DW'(cur_d_reg);
                    cur_m_next = m_prev;
                    cur_y_next = y_prev;
                    cur_d_next = len_prev;
                end
            end

            gda_pkg::ST_RANGE_CHECK: begin
                if ((cur_y_reg == '0) || (cur_y_reg > WY'(MAX_YEAR))) begin
                    bad_next = 1'b1;
                end
                state_next = gda_pkg::ST_OUT;
            end

            gda_pkg::ST_OUT: begin
                // hold the result until taken
                if (m_ready) begin
                    state_next = gda_pkg::ST_IDLE;
                end
            end

            default: state_next = gda_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        order_reg       <= order_next;
        fd_reg          <= fd_next;
        fm_reg          <= fm_next;
        fy_reg          <= fy_next;
        sd_reg          <= sd_next;
        sm_reg          <= sm_next;
        sy_reg          <= sy_next;
        acc_reg         <= acc_next;
        walk_i_reg      <= walk_i_next;
        walk_end_reg    <= walk_end_next;
        walk_year_reg   <= walk_year_next;
        walk_second_reg <= walk_second_next;
        cur_d_reg       <= cur_d_next;
        cur_m_reg       <= cur_m_next;
        cur_y_reg       <= cur_y_next;
        days_reg        <= days_next;
        bad_reg         <= bad_next;
    end

    // clamp the day total
    always_comb begin
        if (acc_reg < 0) begin
            diff_clamped = '0;
        end else if (acc_reg > gda_pkg::acc_t'(gda_pkg::DIFF_MAX)) begin
            diff_clamped = gda_pkg::DIFF_BITS'(gda_pkg::DIFF_MAX);
        end else begin
            diff_clamped = gda_pkg::DIFF_BITS'(acc_reg);
        end
    end

    // result word
    assign diff_sel  = (op_reg == gda_pkg::OP_DIFF);
    assign shift_sel = (op_reg == gda_pkg::OP_ADD) || (op_reg == gda_pkg::OP_SUB);

    assign s_ready          = (state_reg == gda_pkg::ST_IDLE);
    assign m_valid          = (state_reg == gda_pkg::ST_OUT);
    assign m_day_difference = diff_sel ? diff_clamped : '0;
    assign m_date_order     = diff_sel ? order_reg : gda_pkg::ORDER_EQUAL;
    assign m_result_day     = shift_sel ? (bad_reg ? fd_reg : cur_d_reg) : '0;
    assign m_result_month   = shift_sel ? (bad_reg ? fm_reg : cur_m_reg) : '0;
    assign m_result_year    = shift_sel ? (bad_reg ? fy_reg : YB'(cur_y_reg)) : '0;
    assign m_range_error    = shift_sel && bad_reg;

endmodule
